// ===== hw/rtl/ordered_array_engine_top_defines.svh =====
// Assertion helpers used by the engine top module
`ifndef ORDERED_ARRAY_ENGINE_TOP_DEFINES_SVH
`define ORDERED_ARRAY_ENGINE_TOP_DEFINES_SVH

// implication checked at every edge outside reset
`define OAE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication checked in the following cycle
`define OAE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/oae_pkg.sv =====
`timescale 1ns / 1ps
package oae_pkg;
  localparam int Capacity = 64;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = IdxW + 1;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_REMOVE_AT = 3'd1;
  localparam logic [2:0] CMD_REMOVE_VAL = 3'd2;
  localparam logic [2:0] CMD_READ = 3'd3;
  localparam logic [2:0] CMD_SORT = 3'd4;
  localparam logic [2:0] CMD_LSEARCH = 3'd5;
  localparam logic [2:0] CMD_BSEARCH = 3'd6;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // per-cycle control broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD = 3'd0,
    OP_SHIFT_UP = 3'd1,   // cells above pos take left neighbor, pos takes word
    OP_SHIFT_DN = 3'd2,   // cells at or above pos take right neighbor
    OP_SORT_EVEN = 3'd3,  // compare-exchange pairs (2k,2k+1)
    OP_SORT_ODD = 3'd4    // compare-exchange pairs (2k+1,2k+2)
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic [IdxW-1:0] pos;
    logic [CntW-1:0] used;
    logic signed [31:0] word;
  } cell_ctrl_t;
endpackage

// ===== hw/rtl/ordered_array_engine_top.sv =====
`timescale 1ns / 1ps
// channel | signals                          | dir
// in      | valid ready command index value  | into block
// out     | valid ready status data position count | out of block
// Insert, remove at index, remove value, read, linear search: single execute state S_EXEC.
// Binary search: S_BSRCH probes the middle entry until a hit or lo > hi (at most 7 probes).
// Sort: odd-even transposition over the cell row, 64 phases.
// Reset clears the count and control only; entries are written before read.
// The output register frees the engine when a word waits on out ready; a next result waits in S_DONE.
`include "ordered_array_engine_top_defines.svh"
module ordered_array_engine_top (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0] command,
  input  logic [6:0] index,
  input  logic signed [31:0] value,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] status,
  output logic signed [31:0] data,
  output logic [5:0] position,
  output logic [6:0] count
);
  import oae_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_SORT = 5'b00100,
    S_BSRCH = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [2:0] cmd;
  logic [6:0] idx;
  logic signed [31:0] val;
  logic [CntW-1:0] used, used_next;
  logic [CntW-1:0] phase, phase_next;
  logic signed [IdxW+1:0] lo, lo_next, hi, hi_next;
  logic [1:0] res_st, res_st_next;
  logic signed [31:0] res_data, res_data_next;
  logic [IdxW-1:0] res_pos, res_pos_next;
  cell_ctrl_t ctrl;
  logic signed [31:0] words [Capacity];
  logic [Capacity-1:0] hit_vec;
  logic [IdxW-1:0] first_idx;
  logic any_match;
  logic signed [IdxW+1:0] mid;
  logic signed [31:0] mid_word;

  assign in_ready = (state == S_IDLE);

  // cell row
  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    oae_cell u_cell (
      .clk(clk), .ctrl(ctrl), .my_idx(IdxW'(g)),
      .left_word(g == 0 ? words[0] : words[(g+Capacity-1)%Capacity]),
      .right_word(g == Capacity-1 ? words[g] : words[(g+1)%Capacity]),
      .pair_odd(ctrl.op == OP_SORT_ODD ? (g % 2 == 0) : (g % 2 == 1)),
      .word(words[g]), .match(hit_vec[g])
    );
  end

  // first matching cell, lowest index wins
  always_comb begin
    first_idx = '0;
    for (int k = Capacity-1; k >= 0; k--) begin
      if (hit_vec[k]) first_idx = IdxW'(k);
    end
  end
  assign any_match = |hit_vec;

  assign mid = (lo + hi) >>> 1;
  assign mid_word = words[mid[IdxW-1:0]];

  always_comb begin
    state_next = state;
    used_next = used;
    phase_next = phase;
    lo_next = lo;
    hi_next = hi;
    res_st_next = res_st;
    res_data_next = res_data;
    res_pos_next = res_pos;
    ctrl.op = OP_HOLD;
    ctrl.pos = idx[IdxW-1:0];
    ctrl.used = used;
    ctrl.word = val;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        res_st_next = ST_OK;
        res_data_next = '0;
        res_pos_next = '0;
        state_next = S_DONE;
        case (cmd)
          CMD_INSERT: begin
            if (idx > 7'(used)) res_st_next = ST_BAD_INDEX;
            else if (used >= CntW'(Capacity)) res_st_next = ST_FULL;
            else begin
              ctrl.op = OP_SHIFT_UP;
              used_next = used + 1'b1;
            end
          end
          CMD_REMOVE_AT: begin
            if (idx >= 7'(used)) res_st_next = ST_BAD_INDEX;
            else begin
              ctrl.op = OP_SHIFT_DN;
              used_next = used - 1'b1;
            end
          end
          CMD_REMOVE_VAL: begin
            if (!any_match) res_st_next = ST_NOT_FOUND;
            else begin
              ctrl.op = OP_SHIFT_DN;
              ctrl.pos = first_idx;
              used_next = used - 1'b1;
            end
          end
          CMD_READ: begin
            if (idx >= 7'(used)) begin
              res_st_next = ST_BAD_INDEX;
              res_data_next = '1;
            end else res_data_next = words[idx[IdxW-1:0]];
          end
          CMD_SORT: begin
            phase_next = '0;
            state_next = S_SORT;
          end
          CMD_LSEARCH: begin
            if (!any_match) res_st_next = ST_NOT_FOUND;
            else res_pos_next = first_idx;
          end
          CMD_BSEARCH: begin
            lo_next = '0;
            hi_next = (IdxW+2)'(used) - (IdxW+2)'(1);
            res_st_next = ST_NOT_FOUND;
            state_next = S_BSRCH;
          end
          default: ;
        endcase
      end
      S_SORT: begin
        ctrl.op = phase[0] ? OP_SORT_ODD : OP_SORT_EVEN;
        phase_next = phase + 1'b1;
        if (phase == CntW'(Capacity-1)) state_next = S_DONE;
      end
      S_BSRCH: begin
        if (lo > hi) state_next = S_DONE;
        else if (mid_word == val) begin
          res_st_next = ST_OK;
          res_pos_next = mid[IdxW-1:0];
          state_next = S_DONE;
        end else if (mid_word < val) lo_next = mid + (IdxW+2)'(1);
        else hi_next = mid - (IdxW+2)'(1);
      end
      S_DONE: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      used <= used_next;
      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    phase <= phase_next;
    lo <= lo_next;
    hi <= hi_next;
    res_st <= res_st_next;
    res_data <= res_data_next;
    res_pos <= res_pos_next;
    if (state == S_IDLE && in_valid) begin
      cmd <= command;
      idx <= index;
      val <= value;
    end
    if (state == S_DONE && (!out_valid || out_ready)) begin
      status <= res_st;
      data <= res_data;
      position <= res_pos;
      count <= 7'(used);
    end
  end

  `OAE_ASSERT_IMP(a_count_range, 1'b1, used <= CntW'(Capacity), "count exceeds capacity")
  `OAE_ASSERT_NEXT(a_ready_idle, in_valid && in_ready, state == S_EXEC, "accept did not start")
  `OAE_ASSERT_IMP(a_count_out, out_valid, count <= 7'(Capacity), "reported count too big")
  `OAE_ASSERT_NEXT(a_sort_keeps_count, state == S_SORT, used == $past(used), "sort changed count")
endmodule

// ===== hw/rtl/oae_cell.sv =====
`timescale 1ns / 1ps
module oae_cell (
  input  logic clk,
  input  oae_pkg::cell_ctrl_t ctrl,
  input  logic [oae_pkg::IdxW-1:0] my_idx,
  input  logic signed [31:0] left_word,
  input  logic signed [31:0] right_word,
  input  logic pair_odd,      // this cell is the upper member of its pair this phase
  output logic signed [31:0] word,
  output logic match
);
  import oae_pkg::*;

  logic signed [31:0] word_next;
  logic in_range;
  logic partner_ok;
  logic [CntW-1:0] idx_ext;

  assign idx_ext = {1'b0, my_idx};
  assign in_range = idx_ext < ctrl.used;
  assign match = in_range && (word == ctrl.word);

  // compare-exchange partner must also be a live entry
  always_comb begin
    if (pair_odd) partner_ok = in_range && (my_idx != '0);
    else partner_ok = (idx_ext + 1'b1) < ctrl.used;
  end

  always_comb begin
    word_next = word;
    case (ctrl.op)
      OP_SHIFT_UP: begin
        if (my_idx == ctrl.pos) word_next = ctrl.word;
        else if (my_idx > ctrl.pos) word_next = left_word;
      end
      OP_SHIFT_DN: begin
        if (my_idx >= ctrl.pos) word_next = right_word;
      end
      OP_SORT_EVEN, OP_SORT_ODD: begin
        if (partner_ok) begin
          if (pair_odd) begin
            if (word < left_word) word_next = left_word;
          end else begin
            if (right_word < word) word_next = right_word;
          end
        end
      end
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end
endmodule
